// File: sv/kmeans_clustering_engine_assert.svh
// Assertion macros shared by the k-means engine modules.
`ifndef KMEANS_CLUSTERING_ENGINE_ASSERT_SVH
`define KMEANS_CLUSTERING_ENGINE_ASSERT_SVH

// Same-cycle implication, checked on clk, off during rst.
`define KMC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define KMC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/kmc_pkg.sv
// Shared constants, word types and controller codes of the k-means engine.
`timescale 1ns / 1ps
package kmc_pkg;

  localparam int MAX_POINTS   = 1024;
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 8;
  localparam int COORD_WIDTH  = 16;

  localparam int PT_ELEMS = MAX_POINTS * MAX_DIMS;
  localparam int CT_ELEMS = MAX_CLUSTERS * MAX_DIMS;
  localparam int PT_AW    = $clog2(PT_ELEMS);
  localparam int CT_AW    = $clog2(CT_ELEMS);
  localparam int PT_IW    = $clog2(MAX_POINTS);
  localparam int CL_IW    = $clog2(MAX_CLUSTERS);
  localparam int DIM_IW   = $clog2(MAX_DIMS);
  localparam int KC_W     = $clog2(MAX_CLUSTERS + 1);
  localparam int DCNT_W   = $clog2(MAX_DIMS + 1);
  localparam int CNT_W    = $clog2(MAX_POINTS + 1);
  localparam int SUM_W    = COORD_WIDTH + CNT_W;
  localparam int MAG_W    = SUM_W - 1;
  localparam int STEP_W   = $clog2(MAG_W);
  localparam int DIFF_W   = COORD_WIDTH + 1;
  localparam int SQ_W     = 2 * COORD_WIDTH;
  localparam int DIST_W   = SQ_W + DIM_IW;
  localparam int CID_W    = 5;
  localparam int IDX_W    = 13;
  localparam int ROUND_W  = 16;
  localparam int CFG_DW   = 16;
  localparam int CFG_IW   = 2;

  localparam logic [CID_W-1:0]   NO_CLUSTER      = CID_W'(MAX_CLUSTERS);
  localparam logic [KC_W-1:0]    RST_CLUSTERS    = KC_W'(4);
  localparam logic [DCNT_W-1:0]  RST_DIMS        = DCNT_W'(2);
  localparam logic [CNT_W-1:0]   RST_POINTS      = CNT_W'(0);
  localparam logic [ROUND_W-1:0] RST_ITER_LIMIT  = ROUND_W'(100);

  typedef enum logic [2:0] {
    OP_LOAD_POINT   = 3'd0,
    OP_LOAD_CENT    = 3'd1,
    OP_RUN          = 3'd2,
    OP_READ_CLUSTER = 3'd3,
    OP_READ_CENT    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    KIND_RUN     = 2'd0,
    KIND_CLUSTER = 2'd1,
    KIND_CENT    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_CLUSTER_COUNT   = 2'd0,
    REG_DIM_COUNT       = 2'd1,
    REG_POINT_COUNT     = 2'd2,
    REG_ITERATION_LIMIT = 2'd3
  } reg_idx_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_RESULT,
    S_RUN_CHECK,
    S_ROUND_START,
    S_DIST_RD,
    S_DIST_SQ,
    S_DIST_ACC,
    S_DIST_CMP,
    S_ASG_RD,
    S_ASG_WR,
    S_SUM_RD,
    S_SUM_WR,
    S_PT_NEXT,
    S_UPD_CHECK,
    S_UPD_RD,
    S_UPD_DIV,
    S_UPD_WAIT,
    S_UPD_WR,
    S_UPD_NEXT,
    S_ROUND_END
  } state_t;

  typedef struct packed {
    logic [2:0]                    op;
    logic [IDX_W-1:0]              element_index;
    logic signed [COORD_WIDTH-1:0] value;
  } in_word_t;

  typedef struct packed {
    kind_t                         kind;
    logic [CID_W-1:0]              cluster_id;
    logic signed [COORD_WIDTH-1:0] centroid_value;
    logic [ROUND_W-1:0]            rounds_used;
    logic                          converged;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] value;
  } cfg_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load_pt;
    logic load_ct;
    logic clr_step;
    logic rd_issue;
    logic out_load;
    logic run_start;
    logic round_start;
    logic dist_rd;
    logic dist_sq;
    logic dist_acc;
    logic dist_cmp;
    logic asg_rd;
    logic asg_wr;
    logic sum_rd;
    logic sum_wr;
    logic pt_next;
    logic upd_rd;
    logic div_start;
    logic upd_wr;
    logic upd_next;
    logic round_end;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last_clear;
    logic last_dim;
    logic last_cluster;
    logic last_point;
    logic n_zero;
    logic cnt_zero;
    logic div_done;
    logic changed;
    logic more_rounds;
  } stat_t;

endpackage

// File: sv/kmc_stream_if.sv
// Valid/ready channel carrying one word of a given payload type.
`timescale 1ns / 1ps
interface kmc_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: sv/kmc_div.sv
// Restoring divider: signed cluster sum over member count, one bit a cycle.
`timescale 1ns / 1ps
module kmc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [kmc_pkg::SUM_W-1:0] dividend,
  input  logic [kmc_pkg::CNT_W-1:0]        divisor,
  output logic                             done,
  output logic [kmc_pkg::COORD_WIDTH-1:0]  quotient
);
  import kmc_pkg::*;

  logic               busy;
  logic               neg;
  logic [MAG_W-1:0]   q;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   dvs;
  logic [STEP_W-1:0]  step;
  logic [SUM_W-1:0]   mag_in;
  logic [CNT_W:0]     trial;
  logic               fits;
  logic [MAG_W-1:0]   q_signed;

  // Magnitude of the dividend and one trial subtraction
  assign mag_in = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
  assign trial  = {rem, q[MAG_W-1]};
  assign fits   = (trial >= {1'b0, dvs});

  // Advance one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= mag_in[MAG_W-1:0];
      neg <= dividend[SUM_W-1];
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
      q   <= {q[MAG_W-2:0], fits};
    end
  end

  // Restore the sign; truncation toward zero falls out of the magnitude
  assign q_signed = neg ? (~q + MAG_W'(1)) : q;
  assign quotient = q_signed[COORD_WIDTH-1:0];

endmodule

// File: sv/kmc_datapath.sv
// Datapath: stores, distance unit, accumulators, counters and result register.
`timescale 1ns / 1ps
`include "kmeans_clustering_engine_assert.svh"
module kmc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  kmc_pkg::cmd_t       cmd,
  output kmc_pkg::stat_t      stat,
  input  kmc_pkg::in_word_t   in_word,
  input  logic                cfg_write,
  input  kmc_pkg::cfg_word_t  cfg_word,
  output kmc_pkg::out_word_t  out_word
);
  import kmc_pkg::*;

  // Configuration, held already clamped into range
  logic [KC_W-1:0]    k_eff;
  logic [DCNT_W-1:0]  d_eff;
  logic [CNT_W-1:0]   n_eff;
  logic [ROUND_W-1:0] limit;
  logic [KC_W-1:0]    cfg_k;
  logic [DCNT_W-1:0]  cfg_d;
  logic [CNT_W-1:0]   cfg_n;

  // Latched command word
  logic [2:0]       op_l;
  logic [IDX_W-1:0] idx_l;

  // Stores
  logic [COORD_WIDTH-1:0] pt_mem  [PT_ELEMS];
  logic [COORD_WIDTH-1:0] ct_mem  [CT_ELEMS];
  logic [CID_W-1:0]       asg_mem [MAX_POINTS];
  logic [SUM_W-1:0]       sum_mem [CT_ELEMS];
  logic [CT_ELEMS-1:0]    sum_vld;
  logic [CNT_W-1:0]       count   [MAX_CLUSTERS];

  logic [COORD_WIDTH-1:0] pt_rdata;
  logic [COORD_WIDTH-1:0] ct_rdata;
  logic [CID_W-1:0]       asg_rdata;
  logic [SUM_W-1:0]       sum_rdata;
  logic                   sum_rvld;

  // Loop counters and round state
  logic [PT_IW-1:0]   i;
  logic [PT_AW-1:0]   pb;
  logic [CL_IW-1:0]   j;
  logic [CT_AW-1:0]   cb;
  logic [DIM_IW-1:0]  l;
  logic [CT_AW-1:0]   sb;
  logic [CL_IW-1:0]   best;
  logic [DIST_W-1:0]  bestd;
  logic [DIST_W-1:0]  acc;
  logic [SQ_W-1:0]    sq;
  logic [ROUND_W-1:0] round;
  logic               changed;

  logic [PT_AW-1:0]         pt_addr;
  logic [CT_AW-1:0]         cbl;
  logic [CT_AW-1:0]         sbl;
  logic [CT_AW-1:0]         ct_raddr;
  logic [CT_AW-1:0]         ct_waddr;
  logic [COORD_WIDTH-1:0]   ct_wdata;
  logic                     ct_we;
  logic [PT_IW-1:0]         asg_raddr;
  logic [CID_W-1:0]         asg_wdata;
  logic                     asg_we;
  logic [CT_AW-1:0]         sum_raddr;
  logic signed [SUM_W-1:0]  sum_old;
  logic signed [SUM_W-1:0]  sum_wdata;
  logic signed [DIFF_W-1:0] diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [CL_IW+DCNT_W-1:0]  sb_prod;
  logic [DCNT_W-1:0]        d_m1;
  logic [KC_W-1:0]          k_m1;
  logic                     last_dim;
  logic                     last_cluster;
  logic                     ct_load_ok;
  logic                     pt_load_ok;
  logic                     div_done;
  logic [COORD_WIDTH-1:0]   div_q;
  logic                     best_ok;
  logic                     pt_ok;
  out_word_t                out_next;

  // Clamp register writes into their legal ranges
  assign cfg_k = cfg_word.value[KC_W-1:0];
  assign cfg_d = cfg_word.value[DCNT_W-1:0];
  assign cfg_n = cfg_word.value[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff <= RST_CLUSTERS;
      d_eff <= RST_DIMS;
      n_eff <= RST_POINTS;
      limit <= RST_ITER_LIMIT;
    end else if (cfg_write) begin
      case (cfg_word.index)
        REG_CLUSTER_COUNT: begin
          if (cfg_k == '0) k_eff <= KC_W'(1);
          else if (cfg_k > KC_W'(MAX_CLUSTERS)) k_eff <= KC_W'(MAX_CLUSTERS);
          else k_eff <= cfg_k;
        end
        REG_DIM_COUNT: begin
          if (cfg_d == '0) d_eff <= DCNT_W'(1);
          else if (cfg_d > DCNT_W'(MAX_DIMS)) d_eff <= DCNT_W'(MAX_DIMS);
          else d_eff <= cfg_d;
        end
        REG_POINT_COUNT: begin
          n_eff <= (cfg_n > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cfg_n;
        end
        REG_ITERATION_LIMIT: limit <= cfg_word.value[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the command word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_l  <= in_word.op;
      idx_l <= in_word.element_index;
    end
  end

  // Address arithmetic
  assign pt_addr   = pb + PT_AW'(l);
  assign cbl       = cb + CT_AW'(l);
  assign sbl       = sb + CT_AW'(l);
  assign sb_prod   = {{DCNT_W{1'b0}}, best} * {{CL_IW{1'b0}}, d_eff};
  assign d_m1      = d_eff - DCNT_W'(1);
  assign k_m1      = k_eff - KC_W'(1);
  assign last_dim  = (l == d_m1[DIM_IW-1:0]);
  assign last_cluster = (j == k_m1[CL_IW-1:0]);
  assign pt_load_ok = (int'(in_word.element_index) < PT_ELEMS);
  assign ct_load_ok = (int'(in_word.element_index) < CT_ELEMS);

  // Point store: loads write, the round reads
  always_ff @(posedge clk) begin
    if (cmd.load_pt && pt_load_ok) begin
      pt_mem[in_word.element_index[PT_AW-1:0]] <= in_word.value;
    end
    if (cmd.dist_rd || cmd.sum_rd) begin
      pt_rdata <= pt_mem[pt_addr];
    end
  end

  // Centroid store: loads and centroid updates write
  assign ct_we    = (cmd.load_ct && ct_load_ok) || cmd.upd_wr;
  assign ct_waddr = cmd.load_ct ? in_word.element_index[CT_AW-1:0] : cbl;
  assign ct_wdata = cmd.load_ct ? in_word.value : div_q;
  assign ct_raddr = cmd.rd_issue ? idx_l[CT_AW-1:0] : cbl;

  always_ff @(posedge clk) begin
    if (ct_we) begin
      ct_mem[ct_waddr] <= ct_wdata;
    end
    if (cmd.rd_issue || cmd.dist_rd) begin
      ct_rdata <= ct_mem[ct_raddr];
    end
  end

  // Assignment store: cleared by the sweep after reset
  assign asg_we    = cmd.clr_step || cmd.asg_wr;
  assign asg_wdata = cmd.clr_step ? NO_CLUSTER : CID_W'(best);
  assign asg_raddr = cmd.rd_issue ? idx_l[PT_IW-1:0] : i;

  always_ff @(posedge clk) begin
    if (asg_we) begin
      asg_mem[i] <= asg_wdata;
    end
    if (cmd.rd_issue || cmd.asg_rd) begin
      asg_rdata <= asg_mem[asg_raddr];
    end
  end

  // Sum store with valid bits cleared at each round start
  assign sum_raddr = cmd.upd_rd ? cbl : sbl;
  assign sum_old   = sum_rvld ? sum_rdata : '0;
  assign sum_wdata = sum_old + SUM_W'($signed(pt_rdata));

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) begin
      sum_mem[sbl] <= sum_wdata;
    end
    if (cmd.sum_rd || cmd.upd_rd) begin
      sum_rdata <= sum_mem[sum_raddr];
      sum_rvld  <= sum_vld[sum_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.round_start) begin
      sum_vld <= '0;
    end else if (cmd.sum_wr) begin
      sum_vld[sbl] <= 1'b1;
    end
  end

  // Member counts
  always_ff @(posedge clk) begin
    if (cmd.round_start) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        count[c] <= '0;
      end
    end else if (cmd.asg_wr) begin
      count[best] <= count[best] + CNT_W'(1);
    end
  end

  // Squared distance: subtract, square, accumulate
  assign diff = DIFF_W'($signed(pt_rdata)) - DIFF_W'($signed(ct_rdata));
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (cmd.dist_sq) begin
      sq <= prod[SQ_W-1:0];
    end
    if (cmd.round_start || cmd.dist_cmp) begin
      acc <= '0;
    end else if (cmd.dist_acc) begin
      acc <= acc + DIST_W'(sq);
    end
    if (cmd.dist_cmp && ((j == '0) || (acc < bestd))) begin
      best  <= j;
      bestd <= acc;
    end
    if (cmd.asg_rd) begin
      sb <= sb_prod[CT_AW-1:0];
    end
  end

  // Loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      i  <= '0;
      pb <= '0;
      j  <= '0;
      cb <= '0;
      l  <= '0;
    end else begin
      if (cmd.round_start) begin
        i  <= '0;
        pb <= '0;
        j  <= '0;
        cb <= '0;
        l  <= '0;
      end
      if (cmd.clr_step) begin
        i <= i + PT_IW'(1);
      end
      if (cmd.pt_next) begin
        i  <= i + PT_IW'(1);
        pb <= pb + PT_AW'(d_eff);
      end
      if (cmd.dist_acc || cmd.sum_wr || cmd.upd_wr) begin
        l <= last_dim ? '0 : l + DIM_IW'(1);
      end
      if (cmd.dist_cmp || cmd.upd_next) begin
        j  <= last_cluster ? '0 : j + CL_IW'(1);
        cb <= last_cluster ? '0 : cb + CT_AW'(d_eff);
        l  <= '0;
      end
    end
  end

  // Round counter and change flag
  always_ff @(posedge clk) begin
    if (rst) begin
      round   <= '0;
      changed <= 1'b0;
    end else begin
      if (cmd.run_start) begin
        round   <= '0;
        changed <= 1'b1;
      end
      if (cmd.round_start) begin
        changed <= 1'b0;
      end
      if (cmd.asg_wr && (asg_rdata != CID_W'(best))) begin
        changed <= 1'b1;
      end
      if (cmd.round_end) begin
        round <= round + ROUND_W'(1);
      end
    end
  end

  // Mean of a cluster element
  kmc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (sum_old),
    .divisor  (count[j]),
    .done     (div_done),
    .quotient (div_q)
  );

  // Build and hold the result word
  always_comb begin
    out_next = '0;
    case (op_l)
      OP_RUN: begin
        out_next.kind        = KIND_RUN;
        out_next.rounds_used = round;
        out_next.converged   = (round != '0) && !changed;
      end
      OP_READ_CLUSTER: begin
        out_next.kind       = KIND_CLUSTER;
        out_next.cluster_id = (int'(idx_l) < MAX_POINTS) ? asg_rdata : NO_CLUSTER;
      end
      OP_READ_CENT: begin
        out_next.kind           = KIND_CENT;
        out_next.centroid_value = (int'(idx_l) < CT_ELEMS) ? ct_rdata : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word <= out_next;
    end
  end

  // Status to the controller
  always_comb begin
    stat.last_clear   = &i;
    stat.last_dim     = last_dim;
    stat.last_cluster = last_cluster;
    stat.last_point   = (CNT_W'(i) == (n_eff - CNT_W'(1)));
    stat.n_zero       = (n_eff == '0);
    stat.cnt_zero     = (count[j] == '0);
    stat.div_done     = div_done;
    stat.changed      = changed;
    stat.more_rounds  = (round < limit);
  end

  assign best_ok = (KC_W'(best) < k_eff);
  assign pt_ok   = (CNT_W'(i) < n_eff);

  `KMC_ASSERT_IMP(a_best_in_range, cmd.asg_wr, best_ok, "winning cluster beyond cluster count")
  `KMC_ASSERT_IMP(a_point_in_range, cmd.dist_rd, pt_ok, "distance read beyond point count")

endmodule

// File: sv/kmc_ctrl.sv
// Controller: sequences loads, reads and Lloyd rounds over the datapath.
`timescale 1ns / 1ps
`include "kmeans_clustering_engine_assert.svh"
module kmc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic [2:0]     in_op,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output kmc_pkg::cmd_t  cmd,
  input  kmc_pkg::stat_t stat
);
  import kmc_pkg::*;

  state_t state;
  state_t state_next;
  logic   accept;
  logic   result_op;
  logic   result_accept;
  logic   in_wait;

  assign in_ready      = (state == S_IDLE);
  assign accept        = in_valid && in_ready;
  assign result_op     = in_op inside {OP_RUN, OP_READ_CLUSTER, OP_READ_CENT};
  assign result_accept = accept && result_op;
  assign in_wait       = (state == S_UPD_WAIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Hold the result word until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:       if (stat.last_clear) state_next = S_IDLE;
      S_IDLE: begin
        if (accept && (in_op == OP_RUN)) state_next = S_RUN_CHECK;
        else if (accept && (in_op inside {OP_READ_CLUSTER, OP_READ_CENT})) begin
          state_next = S_READ;
        end
      end
      S_READ:        state_next = S_RESULT;
      S_RESULT:      if (!out_valid || out_ready) state_next = S_IDLE;
      S_RUN_CHECK: begin
        state_next = (stat.changed && stat.more_rounds) ? S_ROUND_START : S_RESULT;
      end
      S_ROUND_START: state_next = stat.n_zero ? S_UPD_CHECK : S_DIST_RD;
      S_DIST_RD:     state_next = S_DIST_SQ;
      S_DIST_SQ:     state_next = S_DIST_ACC;
      S_DIST_ACC:    state_next = stat.last_dim ? S_DIST_CMP : S_DIST_RD;
      S_DIST_CMP:    state_next = stat.last_cluster ? S_ASG_RD : S_DIST_RD;
      S_ASG_RD:      state_next = S_ASG_WR;
      S_ASG_WR:      state_next = S_SUM_RD;
      S_SUM_RD:      state_next = S_SUM_WR;
      S_SUM_WR:      state_next = stat.last_dim ? S_PT_NEXT : S_SUM_RD;
      S_PT_NEXT:     state_next = stat.last_point ? S_UPD_CHECK : S_DIST_RD;
      S_UPD_CHECK:   state_next = stat.cnt_zero ? S_UPD_NEXT : S_UPD_RD;
      S_UPD_RD:      state_next = S_UPD_DIV;
      S_UPD_DIV:     state_next = S_UPD_WAIT;
      S_UPD_WAIT:    if (stat.div_done) state_next = S_UPD_WR;
      S_UPD_WR:      state_next = stat.last_dim ? S_UPD_NEXT : S_UPD_RD;
      S_UPD_NEXT:    state_next = stat.last_cluster ? S_ROUND_END : S_UPD_CHECK;
      S_ROUND_END:   state_next = S_RUN_CHECK;
      default:       state_next = S_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd = '0;
    case (state)
      S_CLEAR:       cmd.clr_step = 1'b1;
      S_IDLE: begin
        cmd.capture   = accept;
        cmd.load_pt   = accept && (in_op == OP_LOAD_POINT);
        cmd.load_ct   = accept && (in_op == OP_LOAD_CENT);
        cmd.run_start = accept && (in_op == OP_RUN);
      end
      S_READ:        cmd.rd_issue    = 1'b1;
      S_RESULT:      cmd.out_load    = !out_valid || out_ready;
      S_ROUND_START: cmd.round_start = 1'b1;
      S_DIST_RD:     cmd.dist_rd     = 1'b1;
      S_DIST_SQ:     cmd.dist_sq     = 1'b1;
      S_DIST_ACC:    cmd.dist_acc    = 1'b1;
      S_DIST_CMP:    cmd.dist_cmp    = 1'b1;
      S_ASG_RD:      cmd.asg_rd      = 1'b1;
      S_ASG_WR:      cmd.asg_wr      = 1'b1;
      S_SUM_RD:      cmd.sum_rd      = 1'b1;
      S_SUM_WR:      cmd.sum_wr      = 1'b1;
      S_PT_NEXT:     cmd.pt_next     = 1'b1;
      S_UPD_RD:      cmd.upd_rd      = 1'b1;
      S_UPD_DIV:     cmd.div_start   = 1'b1;
      S_UPD_WR:      cmd.upd_wr      = 1'b1;
      S_UPD_NEXT:    cmd.upd_next    = 1'b1;
      S_ROUND_END:   cmd.round_end   = 1'b1;
      default:       ;
    endcase
  end

  `KMC_ASSERT_IMP(a_no_overwrite, cmd.out_load, !out_valid || out_ready, "result word overwritten")
  `KMC_ASSERT_NXT(a_result_busy, result_accept, state != S_IDLE, "result command not started")
  `KMC_ASSERT_IMP(a_div_expected, stat.div_done, in_wait, "divider finished outside update")

endmodule

// File: sv/kmeans_clustering_engine.sv
// Top level of the Lloyd k-means clustering engine.
//
// Channels: in_ch takes command words (op, element_index, value), out_ch gives
// result words (kind, cluster_id, centroid_value, rounds_used, converged), and
// cfg_ch writes the four registers (cluster, dimension, point counts and the
// round limit); cfg_ch is always ready.
// Point and centroid loads are taken one word per cycle while idle and give no
// result. A cluster or centroid read gives its result word through a read state
// and a result state, which loads it into the output register.
// A run does, per round, an assignment pass over all points, then a centroid
// update of each non-empty cluster through the bit-serial divider; the result
// word follows the last round.
// After reset the assignment store is swept to the unassigned code, while
// in_ch is not ready; the registers take their reset values.
// A result word waits in the output register while out_ch stalls; loads are
// still taken then, but the next read or run completes only once it is taken.
`timescale 1ns / 1ps
module kmeans_clustering_engine (
  input logic            clk,
  input logic            rst,
  kmc_stream_if.sink     in_ch,
  kmc_stream_if.source   out_ch,
  kmc_stream_if.sink     cfg_ch
);
  import kmc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ch.ready = 1'b1;

  kmc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_op     (in_ch.data.op),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  kmc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_ch.data),
    .cfg_write (cfg_ch.valid),
    .cfg_word  (cfg_ch.data),
    .out_word  (out_ch.data)
  );

endmodule
